// ===== rtl/rhht_pkg.sv =====
// Shared types, constants and codes for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
   localparam int SLOTS = 256;
   localparam int IDX_BITS = $clog2(SLOTS);
   localparam int KEY_BITS = 32;
   localparam int VALUE_BITS = 32;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int PL_BITS = IDX_BITS;
   localparam logic [8:0] MAX_ENTRIES_RESET = 9'd217;

   // Register port byte address of max_entries.
   localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_ERASE  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NOT_FOUND = 3'd0,
      ST_FOUND     = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_UPDATED   = 3'd3,
      ST_ERASED    = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LREAD, S_LCHECK, S_PREAD, S_PCHECK, S_EREAD, S_ECHECK, S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [31:0]           found_value;
      logic [8:0]            entries;
   } rsp_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;      // capture request, set index to home
      logic rd;        // read slot at index
      logic advance;   // step index and distance
      logic wr_upd;    // overwrite value at index
      logic wr_swap;   // write carried entry at index, take old one
      logic wr_place;  // write carried entry, mark used, count up
      logic erase_hd;  // clear used at index, count down
      logic shift;     // move next entry back to previous slot
      logic set_fv;    // capture found value
      logic [2:0] status;
      logic set_st;
   } cmd_bus_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       used;
      logic       key_eq;
      logic       poorer;     // dist > stored probe length
      logic       pl_zero;
      logic       walk_end;   // SLOTS slots visited
      logic       full;
   } stat_bus_type;
endpackage
`default_nettype wire

// ===== rtl/rhht_ctrl.sv =====
// Controller state machine for the Robin Hood hash table.
`default_nettype none
module rhht_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  rsp_taken,
   input  wire rhht_pkg::stat_bus_type st,
   output rhht_pkg::cmd_bus_type      cb,
   output logic                       busy,
   output logic                       done
);
   rhht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rhht_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhht_pkg::S_IDLE:   if (start) state_in = rhht_pkg::S_LREAD;
         rhht_pkg::S_LREAD:  state_in = rhht_pkg::S_LCHECK;
         rhht_pkg::S_LCHECK: begin
            priority if (st.walk_end || !st.used || st.poorer) begin
               if (st.cmd == rhht_pkg::CMD_INSERT && !st.full)
                  state_in = rhht_pkg::S_PREAD;
               else state_in = rhht_pkg::S_DONE;
            end else if (st.key_eq) begin
               if (st.cmd == rhht_pkg::CMD_ERASE) state_in = rhht_pkg::S_EREAD;
               else state_in = rhht_pkg::S_DONE;
            end else state_in = rhht_pkg::S_LREAD;
         end
         rhht_pkg::S_PREAD:  state_in = rhht_pkg::S_PCHECK;
         rhht_pkg::S_PCHECK: begin
            if (!st.used || st.walk_end) state_in = rhht_pkg::S_DONE;
            else state_in = rhht_pkg::S_PREAD;
         end
         rhht_pkg::S_EREAD:  state_in = rhht_pkg::S_ECHECK;
         rhht_pkg::S_ECHECK: begin
            if (!st.used || st.pl_zero || st.walk_end) state_in = rhht_pkg::S_DONE;
            else state_in = rhht_pkg::S_EREAD;
         end
         rhht_pkg::S_DONE:   if (rsp_taken) state_in = rhht_pkg::S_IDLE;
         default:            state_in = rhht_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cb = '0;
      busy = (state_ff != rhht_pkg::S_IDLE);
      done = (state_ff == rhht_pkg::S_DONE);
      unique case (state_ff)
         rhht_pkg::S_IDLE: begin
            cb.load = start;
            cb.set_st = start;
            cb.status = rhht_pkg::ST_NOT_FOUND;
         end
         rhht_pkg::S_LREAD, rhht_pkg::S_PREAD: cb.rd = 1'b1;
         rhht_pkg::S_LCHECK: begin
            priority if (st.walk_end || !st.used || st.poorer) begin
               if (st.cmd == rhht_pkg::CMD_INSERT) begin
                  cb.set_st = 1'b1;
                  cb.status = st.full ? rhht_pkg::ST_FULL : rhht_pkg::ST_INSERTED;
               end
            end else if (st.key_eq) begin
               cb.set_st = 1'b1;
               unique case (st.cmd)
                  rhht_pkg::CMD_FIND: begin
                     cb.set_fv = 1'b1;
                     cb.status = rhht_pkg::ST_FOUND;
                  end
                  rhht_pkg::CMD_INSERT: begin
                     cb.wr_upd = 1'b1;
                     cb.status = rhht_pkg::ST_UPDATED;
                  end
                  rhht_pkg::CMD_ERASE: begin
                     cb.erase_hd = 1'b1;
                     cb.status = rhht_pkg::ST_ERASED;
                  end
                  default: cb.set_st = 1'b0;
               endcase
            end else cb.advance = 1'b1;
         end
         rhht_pkg::S_PCHECK: begin
            if (st.walk_end) begin
               cb.advance = 1'b0;
            end else if (!st.used) begin
               cb.wr_place = 1'b1;
            end else begin
               cb.wr_swap = st.poorer;
               cb.advance = 1'b1;
            end
         end
         rhht_pkg::S_EREAD: cb.rd = 1'b1;
         rhht_pkg::S_ECHECK: begin
            if (!(!st.used || st.pl_zero || st.walk_end)) cb.shift = 1'b1;
         end
         rhht_pkg::S_DONE: cb = '0;
         default: cb = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/rhht_datapath.sv =====
// Slot memories, walk index and carried entry of the Robin Hood hash table.
`default_nettype none
module rhht_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rhht_pkg::req_type     req,
   input  wire logic [8:0]            max_entries,
   input  wire rhht_pkg::cmd_bus_type cb,
   output rhht_pkg::stat_bus_type     st,
   output rhht_pkg::rsp_type          rsp
);
   localparam int IB = rhht_pkg::IDX_BITS;
   localparam int CB = rhht_pkg::CNT_BITS;
   localparam int PB = rhht_pkg::PL_BITS;
   localparam int KB = rhht_pkg::KEY_BITS;
   localparam int VB = rhht_pkg::VALUE_BITS;

   logic [KB-1:0] key_mem [rhht_pkg::SLOTS];
   logic [VB-1:0] val_mem [rhht_pkg::SLOTS];
   logic [PB-1:0] pl_mem  [rhht_pkg::SLOTS];
   logic [rhht_pkg::SLOTS-1:0] used_ff;

   logic [1:0]    cmd_ff;
   logic [KB-1:0] key_ff, rkey_ff;
   logic [VB-1:0] val_ff, rval_ff;
   logic [PB-1:0] rpl_ff;
   logic          rused_ff;
   logic [IB-1:0] idx_ff;
   logic [CB-1:0] dist_ff, steps_ff;   // dist: carried probe length; steps: slots visited
   logic [CB-1:0] count_ff;
   logic [2:0]    status_ff;
   logic [31:0]   fv_ff;
   logic [IB-1:0] nidx;

   assign nidx = idx_ff + IB'(1);

   // Registered slot reads; writes at the walk index or the slot behind it.
   always_ff @(posedge clock) begin
      if (cb.rd) begin
         rkey_ff <= key_mem[idx_ff];
         rval_ff <= val_mem[idx_ff];
         rpl_ff  <= pl_mem[idx_ff];
      end
      if (cb.wr_upd) val_mem[idx_ff] <= val_ff;
      if (cb.wr_swap || cb.wr_place) begin
         key_mem[idx_ff] <= key_ff;
         val_mem[idx_ff] <= val_ff;
         pl_mem[idx_ff]  <= dist_ff[PB-1:0];
      end
      if (cb.shift) begin
         key_mem[idx_ff - IB'(1)] <= rkey_ff;
         val_mem[idx_ff - IB'(1)] <= rval_ff;
         pl_mem[idx_ff - IB'(1)]  <= rpl_ff - PB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
         rused_ff <= 1'b0;
      end else begin
         if (cb.rd) rused_ff <= used_ff[idx_ff];
         if (cb.wr_place) begin
            used_ff[idx_ff] <= 1'b1;
            count_ff <= count_ff + CB'(1);
         end
         if (cb.erase_hd) begin
            used_ff[idx_ff] <= 1'b0;
            count_ff <= count_ff - CB'(1);
         end
         if (cb.shift) begin
            used_ff[idx_ff - IB'(1)] <= 1'b1;
            used_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cb.load) begin
         cmd_ff   <= req.cmd;
         key_ff   <= req.key;
         val_ff   <= req.value;
         idx_ff   <= req.key[IB-1:0];
         dist_ff  <= '0;
         steps_ff <= '0;
         fv_ff    <= '0;
      end else begin
         if (cb.set_fv) fv_ff <= rval_ff;
         if (cb.wr_swap) begin
            key_ff  <= rkey_ff;
            val_ff  <= rval_ff;
            dist_ff <= CB'(rpl_ff) + CB'(1);
         end else if (cb.advance) begin
            dist_ff <= dist_ff + CB'(1);
         end
         if (cb.advance) begin
            idx_ff   <= nidx;
            steps_ff <= steps_ff + CB'(1);
         end
         // Erase: head cleared, then walk starts at the next slot.
         if (cb.erase_hd || cb.shift) begin
            idx_ff   <= nidx;
            steps_ff <= cb.erase_hd ? '0 : steps_ff + CB'(1);
         end
      end
      if (cb.set_st) status_ff <= cb.status;
   end

   always_comb begin
      st.cmd      = cmd_ff;
      st.used     = rused_ff;
      st.key_eq   = (rkey_ff == key_ff);
      st.poorer   = (dist_ff > CB'(rpl_ff));
      st.pl_zero  = (rpl_ff == '0);
      st.walk_end = (steps_ff == CB'(rhht_pkg::SLOTS));
      st.full     = (CB'(count_ff) >= CB'(max_entries)) ||
                    (count_ff >= CB'(rhht_pkg::SLOTS));
      rsp.status      = status_ff;
      rsp.found_value = fv_ff;
      rsp.entries     = count_ff;
   end
endmodule
`default_nettype wire

// ===== rtl/robin_hood_hash_table.sv =====
// Top level of the Robin Hood hash table: handshakes, register port, controller and datapath.
// Each slot probed passes through a read and a check state, as does each slot visited by the insert or shift walk.
// Requests are handled one at a time; the next is taken in the cycle after the response is accepted.
// The probe walk over the slot memories, one registered read per step, sets the rate.
// Reset clears used bits, entry count and control; max_entries resets to 217.
// Slot keys, values and probe lengths are not cleared; no clearing pass is needed.
`default_nettype none
module robin_hood_hash_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rhht_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rhht_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [1:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   rhht_pkg::cmd_bus_type  cb;
   rhht_pkg::stat_bus_type st;
   logic [8:0] max_ff;
   logic busy, done;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_ff <= rhht_pkg::MAX_ENTRIES_RESET;
      else if (psel && penable && pwrite && paddr == rhht_pkg::REG_MAX_ENTRIES)
         max_ff <= pwdata[8:0];
   end
   assign prdata = (paddr == rhht_pkg::REG_MAX_ENTRIES) ? {23'd0, max_ff} : 32'd0;

   assign req_ready = !busy && !reset;
   assign rsp_valid = done;

   rhht_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_valid && req_ready),
      .rsp_taken(rsp_ready), .st(st), .cb(cb), .busy(busy), .done(done)
   );

   rhht_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .max_entries(max_ff),
      .cb(cb), .st(st), .rsp(rsp_data)
   );

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entries <= 9'(rhht_pkg::SLOTS))
      else $error("entry count beyond capacity");
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");
endmodule
`default_nettype wire

// ===== tb/robin_hood_hash_table_checker.sv =====
// Checker for the Robin Hood hash table: tracks requests, predicts responses and compares them.
`timescale 1ns / 100ps
module robin_hood_hash_table_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire rhht_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rhht_pkg::rsp_type rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [1:0]        paddr,
   input  wire logic [31:0]       pwdata,
   input  wire logic              pready,
   output int                     fail_count,
   output int                     pending_count
);
   logic [31:0]       tbl_key [rhht_pkg::SLOTS];
   logic [31:0]       tbl_val [rhht_pkg::SLOTS];
   int                tbl_dist [rhht_pkg::SLOTS];
   bit                tbl_used [rhht_pkg::SLOTS];
   int                held;
   logic [8:0]        limit;
   rhht_pkg::rsp_type rsp_queue [$];

   function automatic int home_of(logic [31:0] k);
      return int'(k[rhht_pkg::IDX_BITS-1:0]);
   endfunction

   function automatic bit find_slot(logic [31:0] k, output int where);
      int idx;
      idx = home_of(k);
      where = 0;
      for (int d = 0; d < rhht_pkg::SLOTS; d++) begin
         if (!tbl_used[idx] || d > tbl_dist[idx]) return 0;
         if (tbl_key[idx] == k) begin
            where = idx;
            return 1;
         end
         idx = (idx + 1) % rhht_pkg::SLOTS;
      end
      return 0;
   endfunction

   function automatic void place_key(logic [31:0] k, logic [31:0] v);
      int idx, d, td;
      logic [31:0] tk, tv;
      idx = home_of(k);
      d = 0;
      for (int n = 0; n < rhht_pkg::SLOTS; n++) begin
         if (!tbl_used[idx]) begin
            tbl_key[idx] = k; tbl_val[idx] = v; tbl_dist[idx] = d;
            tbl_used[idx] = 1; held++;
            return;
         end
         if (d > tbl_dist[idx]) begin
            tk = tbl_key[idx]; tv = tbl_val[idx]; td = tbl_dist[idx];
            tbl_key[idx] = k; tbl_val[idx] = v; tbl_dist[idx] = d;
            k = tk; v = tv; d = td;
         end
         idx = (idx + 1) % rhht_pkg::SLOTS;
         d++;
      end
   endfunction

   function automatic void remove_slot(int idx);
      int cur, nxt;
      cur = idx;
      nxt = (cur + 1) % rhht_pkg::SLOTS;
      tbl_used[cur] = 0;
      held--;
      for (int n = 0; n < rhht_pkg::SLOTS; n++) begin
         if (!tbl_used[nxt] || tbl_dist[nxt] == 0) break;
         tbl_key[cur] = tbl_key[nxt]; tbl_val[cur] = tbl_val[nxt];
         tbl_dist[cur] = tbl_dist[nxt] - 1;
         tbl_used[cur] = 1; tbl_used[nxt] = 0;
         cur = nxt;
         nxt = (cur + 1) % rhht_pkg::SLOTS;
      end
   endfunction

   function automatic rhht_pkg::rsp_type predict_table(rhht_pkg::req_type r);
      rhht_pkg::rsp_type o;
      int where;
      o = '0;
      o.status = rhht_pkg::ST_NOT_FOUND;
      case (r.cmd)
         rhht_pkg::CMD_FIND: if (find_slot(r.key, where)) begin
            o.status = rhht_pkg::ST_FOUND;
            o.found_value = tbl_val[where];
         end
         rhht_pkg::CMD_INSERT: begin
            if (find_slot(r.key, where)) begin
               tbl_val[where] = r.value;
               o.status = rhht_pkg::ST_UPDATED;
            end else if (held >= int'(limit) || held >= rhht_pkg::SLOTS) begin
               o.status = rhht_pkg::ST_FULL;
            end else begin
               place_key(r.key, r.value);
               o.status = rhht_pkg::ST_INSERTED;
            end
         end
         rhht_pkg::CMD_ERASE: if (find_slot(r.key, where)) begin
            remove_slot(where);
            o.status = rhht_pkg::ST_ERASED;
         end
         default: ;
      endcase
      o.entries = 9'(held);
      return o;
   endfunction

   assign pending_count = rsp_queue.size();

   always @(posedge clock) begin
      rhht_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < rhht_pkg::SLOTS; i++) tbl_used[i] = 0;
         held = 0;
         limit = rhht_pkg::MAX_ENTRIES_RESET;
         rsp_queue.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == rhht_pkg::REG_MAX_ENTRIES)
            limit = pwdata[8:0];
         if (req_valid && req_ready)
            rsp_queue.push_back(predict_table(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_data.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
               if (rsp_data.found_value !== want.found_value)
                  $display("%0t: found_value expected %h actual %h", $time,
                           want.found_value, rsp_data.found_value);
               if (rsp_data.entries !== want.entries)
                  $display("%0t: entries expected %0d actual %0d", $time,
                           want.entries, rsp_data.entries);
               if (rsp_data !== want) fail_count++;
            end
         end
      end
   end
endmodule

// ===== tb/robin_hood_hash_table_tb.sv =====
// Testbench top for the Robin Hood hash table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module robin_hood_hash_table_tb;
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rhht_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rhht_pkg::rsp_type rsp_data;
   logic              psel, penable, pwrite;
   logic [1:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                fail_count;
   int                pending_count;
   bit                hold_off;
   bit                stim_done;
   logic [31:0]       key_pool [16];

   robin_hood_hash_table uut (.*);

   robin_hood_hash_table_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic write_limit(logic [8:0] v);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = rhht_pkg::REG_MAX_ENTRIES;
      pwdata = 32'(v);
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Offer one request at the falling edge, hold until accepted.
   task automatic send_request(logic [1:0] c, logic [31:0] k, logic [31:0] v);
      req_valid = 1;
      req_data = '{cmd: c, key: k, value: v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain_responses();
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1, 2:    return {24'($urandom_range(0, 7)), 8'h05}; // collide on one home slot
         default: return key_pool[$urandom_range(0, 15)];
      endcase
   endfunction

   // Random stimulus in bursts, most of them followed by a random gap.
   task automatic random_phase(int count);
      int burst;
      int n;
      logic [1:0] c;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (n < count) begin
               c = ($urandom_range(0, 19) == 0) ? rhht_pkg::CMD_NONE :
                                                  2'($urandom_range(0, 2));
               send_request(c, pick_key(), $urandom());
               n++;
            end
         end
         if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || stim_done;
   end

   initial begin
      req_valid = 0; req_data = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      hold_off = 0; stim_done = 0;
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF; key_pool[2] = 32'h0000_0100;
      key_pool[3] = 32'h0000_00FF; key_pool[4] = 32'h0000_01FF;
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, each command, colliding keys, unused code, small limit.
      send_request(rhht_pkg::CMD_FIND, 32'h0, 32'h0);
      send_request(rhht_pkg::CMD_ERASE, 32'h0, 32'h0);
      send_request(rhht_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_request(rhht_pkg::CMD_INSERT, 32'h100, 32'h1234_5678);
      send_request(rhht_pkg::CMD_INSERT, 32'h200, 32'hA5A5_A5A5);
      send_request(rhht_pkg::CMD_INSERT, 32'h1, 32'h0);
      send_request(rhht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      send_request(rhht_pkg::CMD_INSERT, 32'h0000_00FF, 32'h1);
      send_request(rhht_pkg::CMD_FIND, 32'h200, 32'h0);
      send_request(rhht_pkg::CMD_FIND, 32'h300, 32'h0);
      send_request(rhht_pkg::CMD_INSERT, 32'h100, 32'hDEAD_BEEF);
      send_request(rhht_pkg::CMD_FIND, 32'h100, 32'h0);
      send_request(rhht_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rhht_pkg::CMD_ERASE, 32'h0, 32'h0);
      send_request(rhht_pkg::CMD_FIND, 32'h200, 32'h0);
      send_request(rhht_pkg::CMD_FIND, 32'h1, 32'h0);
      drain_responses();
      write_limit(9'd6);
      send_request(rhht_pkg::CMD_INSERT, 32'h7777, 32'h1);
      send_request(rhht_pkg::CMD_INSERT, 32'h8888, 32'h2);
      send_request(rhht_pkg::CMD_INSERT, 32'h1, 32'h3);
      drain_responses();
      write_limit(9'd0);
      send_request(rhht_pkg::CMD_INSERT, 32'h9999, 32'h4);
      send_request(rhht_pkg::CMD_INSERT, 32'h0000_00FF, 32'h5);
      drain_responses();

      // Hold off the receiver while requests keep coming.
      write_limit(9'd511);
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         random_phase(20);
      join
      random_phase(250);
      drain_responses();
      write_limit(9'd256);
      for (int i = 0; i < 300; i++)
         send_request(rhht_pkg::CMD_INSERT, $urandom(), $urandom());
      random_phase(150);
      drain_responses();
      write_limit(9'd1);
      random_phase(80);
      drain_responses();
      write_limit(9'($urandom_range(20, 200)));
      random_phase(200);
      drain_responses();
      write_limit(9'd217);
      random_phase(100);
      stim_done = 1;
      drain_responses();

      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
